@@ design/bft_pkg.sv @@
package bft_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int ENTRY_W  = 2 * KEY_W;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int SERIAL_W = 4;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CMD_W-1:0]        cmd_t;
  typedef logic [STATUS_W-1:0]     status_t;
  typedef logic [SERIAL_W-1:0]     serial_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ENTRY_W-1:0]      entry_t;

  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_QUERY_W = 2'd1;
  localparam cmd_t CMD_QUERY_V = 2'd2;

  localparam status_t ST_ADDED = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_FOUND = 2'd2;
  localparam status_t ST_NONE  = 2'd3;

  localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EMIT
  } state_e;

endpackage

@@ design/best_fit_two_key_table_unit.sv @@
// best fit table: stores up to CAPACITY entries of two signed keys each
// (weight, volume) and answers best-fit queries on either key.
// input channel (in_valid_i/in_ready_o) carries one request: cmd_i selects
// add, query by weight or query by volume; weight_i/volume_i are the keys to
// add, threshold_i the lower bound of a query.
// output channel (out_valid_o/out_ready_i) returns one result per request:
// status_o (added, full, found, not found) and serial_o (slot index or 0).
// an add, also on a full table, an unused command and a query on an empty
// table go straight to the result state; a query scans the stored entries,
// one entry read from the key memory and compared per cycle.
// one request is worked on at a time; the next is taken once the previous
// result sits in the output register, so a stalled receiver holds at most
// one finished result plus one request in progress.
// reset empties the table (entry count to zero) and drops any pending
// result; stored key memory is not cleared and needs no clearing pass.
module best_fit_two_key_table_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bft_pkg::cmd_t     cmd_i,
  input  bft_pkg::key_t     weight_i,
  input  bft_pkg::key_t     volume_i,
  input  bft_pkg::key_t     threshold_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bft_pkg::status_t  status_o,
  output bft_pkg::serial_t  serial_o
);
  import bft_pkg::*;

  entry_t  mem_q [CAPACITY];
  entry_t  rd_data_q;
  idx_t    rd_addr;
  logic    wr_en;

  state_e  state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  idx_t    idx_q, idx_d;
  logic    sel_vol_q, sel_vol_d;
  key_t    thr_q, thr_d;
  key_t    best_q, best_d;
  idx_t    best_idx_q, best_idx_d;
  logic    found_q, found_d;
  status_t res_status_q, res_status_d;
  serial_t res_serial_q, res_serial_d;
  logic    out_valid_q, out_valid_d;
  status_t out_status_q, out_status_d;
  serial_t out_serial_q, out_serial_d;

  logic    in_acc;
  logic    out_free;
  logic    last;
  logic    hit;
  key_t    cand;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign last     = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
  assign cand     = sel_vol_q ? key_t'(rd_data_q[KEY_W-1:0])
                              : key_t'(rd_data_q[ENTRY_W-1:KEY_W]);
  // strict less-than keeps the lowest index on equal keys
  assign hit      = (cand >= thr_q) && (cand < best_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          if ((cmd_i == CMD_QUERY_W || cmd_i == CMD_QUERY_V) && cnt_q != '0) begin
            state_d = FSM_SCAN;
          end else begin
            state_d = FSM_EMIT;
          end
        end
      end
      FSM_SCAN: begin
        if (last) state_d = FSM_EMIT;
      end
      FSM_EMIT: begin
        if (out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o   = 1'b0;
    wr_en        = 1'b0;
    rd_addr      = '0;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    sel_vol_d    = sel_vol_q;
    thr_d        = thr_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_serial_d = res_serial_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_serial_d = out_serial_q;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o   = 1'b1;
        idx_d        = '0;
        best_d       = KEY_MAX;
        best_idx_d   = '0;
        found_d      = 1'b0;
        thr_d        = threshold_i;
        sel_vol_d    = (cmd_i == CMD_QUERY_V);
        res_status_d = ST_NONE;
        res_serial_d = '0;
        if (in_acc) begin
          case (cmd_i)
            CMD_ADD: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                cnt_d        = cnt_q + CNT_W'(1);
                res_status_d = ST_ADDED;
                res_serial_d = SERIAL_W'(cnt_q);
              end
            end
            default: ;
          endcase
        end
      end
      FSM_SCAN: begin
        rd_addr = idx_q + IDX_W'(1);
        idx_d   = idx_q + IDX_W'(1);
        if (hit) begin
          best_d     = cand;
          best_idx_d = idx_q;
          found_d    = 1'b1;
        end
        if (last) begin
          if (hit || found_q) begin
            res_status_d = ST_FOUND;
            res_serial_d = hit ? SERIAL_W'(idx_q) : SERIAL_W'(best_idx_q);
          end else begin
            res_status_d = ST_NONE;
            res_serial_d = '0;
          end
        end
      end
      FSM_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_serial_d = res_serial_q;
        end
      end
      default: ;
    endcase
  end

  // key memory, both keys of one entry in one word
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[cnt_q[IDX_W-1:0]] <= {weight_i, volume_i};
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    sel_vol_q    <= sel_vol_d;
    thr_q        <= thr_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    found_q      <= found_d;
    res_status_q <= res_status_d;
    res_serial_q <= res_serial_d;
    out_status_q <= out_status_d;
    out_serial_q <= out_serial_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign serial_o    = out_serial_q;

endmodule

@@ design/bft_checker.sv @@
module bft_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  bft_pkg::cmd_t     cmd_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  bft_pkg::status_t  status_o,
  input  bft_pkg::serial_t  serial_o
);
  import bft_pkg::*;

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(serial_o))
    else $error("result changed while stalled");

  // full and not found carry serial zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_NONE) |-> serial_o == '0)
    else $error("nonzero serial without an entry");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // an add taken with the output register empty reports added or full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_ADD && !out_valid_o |=> ##1
      out_valid_o && (status_o == ST_ADDED || status_o == ST_FULL))
    else $error("add gave wrong status");

endmodule

bind best_fit_two_key_table_unit bft_checker u_bft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .serial_o    (serial_o)
);
